// ===== design/assert_macros.svh =====
// Assertion helpers for the design files (included by indexed_list_insert_delete)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ilid_pkg.sv =====
`default_nettype none

package ilid_pkg;

  // Opcodes of an input beat
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Actions broadcast along the row of cells
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_READ = 2'd1;
  localparam logic [1:0] CELL_INS  = 2'd2;
  localparam logic [1:0] CELL_DEL  = 2'd3;

  // Positions that reach the cells are already non-negative and below 128
  typedef struct packed {
    logic [1:0] act;
    logic [6:0] pos;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/ilid_cell.sv =====
`default_nettype none

module ilid_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  ilid_pkg::cell_cmd_t cmd,
  input  logic [31:0]        ins_value,
  input  logic [31:0]        left,
  input  logic [31:0]        right,
  output logic [31:0]        entry,
  output logic [31:0]        rd_part
);
  import ilid_pkg::*;

  localparam logic [31:0] IDX_W = 32'(IDX);

  logic [31:0] pos_w;
  logic        at_pos;
  logic        above_pos;

  // slot position compare
  assign pos_w     = {25'b0, cmd.pos};
  assign at_pos    = (IDX_W == pos_w);
  assign above_pos = (IDX_W > pos_w);

  // read contribution: only the addressed slot drives the bus
  assign rd_part = ((cmd.act == CELL_READ) && at_pos) ? entry : 32'b0;

  // shift up on insert, shift down on remove
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      CELL_INS: begin
        if (above_pos) begin
          entry <= left;
        end else if (at_pos) begin
          entry <= ins_value;
        end
      end
      CELL_DEL: begin
        if (above_pos || at_pos) begin
          entry <= right;
        end
      end
      CELL_HOLD, CELL_READ: begin
        entry <= entry;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/indexed_list_insert_delete.sv =====
// Positional list of signed 32-bit entries held in a row of shifting cells.
// Result strobe (done) follows the start beat through stage one (v1) and the result register.
// Throughput: one beat every cycle; busy stays low, the read path is a
// two-stage registered OR tree over the cells' read outputs.
// Reset (rst, synchronous): clears the entry count and the result pipeline;
// entry contents are undefined until written. The receiver cannot stall.
`default_nettype none

module indexed_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [7:0]  position,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [6:0]         entry_count
);
  import ilid_pkg::*;

  `include "assert_macros.svh"

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CMPW   = ((CW > 8) ? CW : 8) + 1;
  localparam int GROUP  = 32;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  cell_cmd_t   cmd;
  logic [1:0]  st_next;
  logic        rdneg_next;

  logic [31:0] entry   [CAPACITY];
  logic [31:0] rd_part [CAPACITY];
  logic [31:0] grp_or_next [NGROUP];
  logic [31:0] grp_or      [NGROUP];
  logic [31:0] all_or;

  logic          v1;
  logic [1:0]    st1;
  logic          rdneg1;
  logic [CW-1:0] cnt1;

  logic signed [CMPW-1:0] pos_ext;
  logic signed [CMPW-1:0] cnt_ext;
  logic pos_neg;
  logic pos_ge;
  logic pos_gt;
  logic is_full;

  assign busy = 1'b0;

  // position against count
  assign pos_ext = {{(CMPW-8){position[7]}}, position};
  assign cnt_ext = {{(CMPW-CW){1'b0}}, count};
  assign pos_neg = position[7];
  assign pos_ge  = (pos_ext >= cnt_ext);
  assign pos_gt  = (pos_ext > cnt_ext);
  assign is_full = (count == CW'(CAPACITY));

  // decode the beat into a cell action and a status
  always_comb begin
    cmd.act    = CELL_HOLD;
    cmd.pos    = position[6:0];
    st_next    = ST_DONE;
    rdneg_next = 1'b0;
    count_next = count;
    if (start) begin
      unique case (opcode)
        OP_READ: begin
          if (pos_neg || pos_ge) begin
            st_next    = ST_RANGE;
            rdneg_next = 1'b1;
          end else begin
            cmd.act = CELL_READ;
          end
        end
        OP_INSERT: begin
          if (pos_gt) begin
            st_next = ST_RANGE;
          end else if (is_full) begin
            st_next = ST_FULL;
          end else begin
            cmd.act    = CELL_INS;
            cmd.pos    = pos_neg ? 7'd0 : position[6:0];
            count_next = count + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (pos_neg || pos_ge) begin
            st_next = ST_RANGE;
          end else begin
            cmd.act    = CELL_DEL;
            count_next = count - 1'b1;
          end
        end
        OP_NONE: begin
          st_next = ST_DONE;
        end
      endcase
    end
  end

  // row of cells linked to neighbours; the ends use value and their own entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_in;
    logic [31:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = entry[i];
    end else begin : g_mid_r
      assign right_in = entry[i+1];
    end
    ilid_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .ins_value (value),
      .left      (left_in),
      .right     (right_in),
      .entry     (entry[i]),
      .rd_part   (rd_part[i])
    );
  end

  // read bus, first level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_or_next[g] = 32'b0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_or_next[g] = grp_or_next[g] | rd_part[g * GROUP + k];
        end
      end
    end
  end

  // read bus, second level: OR across groups
  always_comb begin
    all_or = 32'b0;
    for (int g = 0; g < NGROUP; g++) begin
      all_or = all_or | grp_or[g];
    end
  end

  // count and stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v1    <= 1'b0;
    end else begin
      count <= count_next;
      v1    <= start;
    end
    st1    <= st_next;
    rdneg1 <= rdneg_next;
    cnt1   <= count_next;
    grp_or <= grp_or_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    read_value  <= rdneg1 ? 32'hFFFF_FFFF : all_or;
    status      <= st1;
    entry_count <= 7'(cnt1);
  end

  `ASSERT_CLK(a_count_bound, clk, rst, count <= CW'(CAPACITY), "count above capacity")
  `ASSERT_CLK(a_one_result, clk, rst, start |-> ##2 done, "missing result")
  `ASSERT_CLK(a_no_extra, clk, rst, !start |-> ##2 !done, "result without a beat")
  `ASSERT_CLK(a_full_count, clk, rst, (done && status == ST_FULL) |-> (entry_count == 7'(CAPACITY)), "full status with spare room")

endmodule

`default_nettype wire
